>>> rtl/assert_macros.svh
// Assertion macros for the RTL, used by the top module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/mrdu_pkg.sv
`default_nettype none

package mrdu_pkg;

    localparam int UNITS_DEF   = 2;
    localparam int DOMAINS_DEF = 16;
    localparam int REGIONS_DEF = 8;

    localparam int GRAN_SHIFT = 14;
    localparam int GRAN_W     = 18;
    localparam int ADDR_W     = 32;
    localparam int GROUP_W    = 3;

    localparam logic [1:0] UNIT_COUNT_RST = 2'd2;
    localparam logic [3:0] GROUP_LIMIT    = 4'd8;

    localparam logic CMD_CONFIG = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_FREE = 2'd2
    } t_status;

    // Stored descriptor payload; the valid bit lives in flip-flops
    typedef struct packed {
        logic [GRAN_W-1:0]  gran_lo;
        logic [GRAN_W-1:0]  gran_hi;
        logic [GROUP_W-1:0] group;
        logic               nonsecure;
    } t_desc;

    // Result item, status in the low bits
    typedef struct packed {
        logic               read_nonsecure;
        logic               read_valid;
        logic [GROUP_W-1:0] read_group;
        logic [GRAN_W-1:0]  read_end;
        logic [GRAN_W-1:0]  read_start;
        logic [2:0]         new_slot;
        logic               new_entry;
        logic               covered;
        t_status            status;
    } t_result;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic rd_slot;
        logic eval;
        logic fill;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic bad;
        logic is_read;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/memory_region_descriptor_update_top.sv
// Channel   Direction  Signals                      Content
// s_axis    in         tvalid tready tdata tuser    request: configure or read
// m_axis    out        tvalid tready tdata          one result per request
// cfg       in         valid ready data             unit_count register
//
// A configure request reads one descriptor a cycle through the single memory
// read port; each is evaluated in the cycle after its read, then a free slot
// is filled if the range is not covered, and the result is loaded.
// A read request reads its slot first; a rejected one goes straight to the result.
// Reset is synchronous, active low, and clears the descriptor valid bits at once.
// A stalled result holds in the output register; the next request then waits
// in its last state, which holds off the input.
`default_nettype none
`include "assert_macros.svh"

module memory_region_descriptor_update_top #(
    parameter int UNITS   = mrdu_pkg::UNITS_DEF,
    parameter int DOMAINS = mrdu_pkg::DOMAINS_DEF,
    parameter int REGIONS = mrdu_pkg::REGIONS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // unit, domain, range_start, range_end, secure_only, group_id, slot, 2 pad
    input  wire logic [79:0] i_s_axis_tdata,
    // cmd
    input  wire logic [0:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status, covered, new_entry, new_slot, read_start, read_end, read_group,
    // read_valid, read_nonsecure
    output logic [47:0]      o_m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data
);
    import mrdu_pkg::*;

    localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    t_dp_cmd        w_cmd;
    t_dp_stat       w_stat;
    t_result        w_result;
    logic [RW-1:0]  w_idx;
    logic           w_new_shown;
    logic           w_new_clean;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = w_result;

    mrdu_ctrl #(
        .REGIONS (REGIONS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_idx     (w_idx)
    );

    mrdu_dp #(
        .UNITS   (UNITS),
        .DOMAINS (DOMAINS),
        .REGIONS (REGIONS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (w_cmd),
        .i_idx           (w_idx),
        .i_f_cmd         (i_s_axis_tuser[0]),
        .i_f_unit        (i_s_axis_tdata[1:0]),
        .i_f_domain      (i_s_axis_tdata[5:2]),
        .i_f_start       (i_s_axis_tdata[37:6]),
        .i_f_end         (i_s_axis_tdata[69:38]),
        .i_f_secure_only (i_s_axis_tdata[70]),
        .i_f_group       (i_s_axis_tdata[74:71]),
        .i_f_slot        (i_s_axis_tdata[77:75]),
        .o_stat          (w_stat),
        .o_result        (w_result)
    );

    assign w_new_shown = o_m_axis_tvalid && w_result.new_entry;
    assign w_new_clean = (w_result.status == ST_OK) && !w_result.covered;

    // no descriptor write while waiting for a request
    `ASSERT_IMPL(a_no_write_idle, i_clk, i_rst_n, o_s_axis_tready, !w_cmd.eval && !w_cmd.fill)
    // never overwrite a result that has not been taken
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_cmd.load_out, !o_m_axis_tvalid || i_m_axis_tready)
    // a filled slot means success without cover
    `ASSERT_IMPL(a_new_entry_ok, i_clk, i_rst_n, w_new_shown, w_new_clean)
    // one request at a time
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

`default_nettype wire

>>> rtl/mrdu_ctrl.sv
`default_nettype none

module mrdu_ctrl #(
    parameter int REGIONS = mrdu_pkg::REGIONS_DEF,
    localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1,
    localparam int CW = $clog2(REGIONS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    output logic                   o_s_ready,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    input  mrdu_pkg::t_dp_stat     i_stat,
    output mrdu_pkg::t_dp_cmd      o_cmd,
    output logic [RW-1:0]          o_idx
);
    import mrdu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_FILL,
        S_DONE
    } t_state;

    localparam logic [CW-1:0] CNT_END = CW'(REGIONS);

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic            r_evp;
    logic            r_out_valid;
    logic            scan_rd;

    assign scan_rd   = (r_state == S_SCAN) && (r_cnt != CNT_END);
    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_idx     = r_cnt[RW-1:0];

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_s_valid;
        o_cmd.rd_en    = (r_state == S_READ) || scan_rd;
        o_cmd.rd_slot  = (r_state == S_READ);
        o_cmd.eval     = (r_state == S_SCAN) && r_evp;
        o_cmd.fill     = (r_state == S_FILL);
        o_cmd.load_out = (r_state == S_DONE) && (!r_out_valid || i_m_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_evp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_evp <= 1'b0;
                    if (i_s_valid) begin
                        if (i_stat.bad) begin
                            r_state <= S_DONE;
                        end else if (i_stat.is_read) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_DONE;
                end
                S_SCAN: begin
                    // read slot k while slot k-1 is evaluated
                    r_evp <= scan_rd;
                    if (scan_rd) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/mrdu_dp.sv
`default_nettype none

module mrdu_dp #(
    parameter int UNITS   = mrdu_pkg::UNITS_DEF,
    parameter int DOMAINS = mrdu_pkg::DOMAINS_DEF,
    parameter int REGIONS = mrdu_pkg::REGIONS_DEF,
    localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_data,
    input  mrdu_pkg::t_dp_cmd  i_cmd,
    input  wire logic [RW-1:0] i_idx,
    input  wire logic          i_f_cmd,
    input  wire logic [1:0]    i_f_unit,
    input  wire logic [3:0]    i_f_domain,
    input  wire logic [31:0]   i_f_start,
    input  wire logic [31:0]   i_f_end,
    input  wire logic          i_f_secure_only,
    input  wire logic [3:0]    i_f_group,
    input  wire logic [2:0]    i_f_slot,
    output mrdu_pkg::t_dp_stat o_stat,
    output mrdu_pkg::t_result  o_result
);
    import mrdu_pkg::*;

    localparam int DEPTH = UNITS * DOMAINS * REGIONS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_desc               r_mem [DEPTH];
    logic [DEPTH-1:0]    r_vld;

    logic [1:0]          r_unit_count;
    logic                r_is_read;
    logic                r_bad;
    logic [AW-1:0]       r_base;
    logic [GRAN_W-1:0]   r_astart;
    logic [GRAN_W-1:0]   r_aend;
    logic [GROUP_W-1:0]  r_group;
    logic                r_ns;
    logic [2:0]          r_slot;
    logic                r_hit;
    logic                r_have_free;
    logic [RW-1:0]       r_free_idx;

    t_desc               r_rd;
    logic                r_rd_vld;
    logic [AW-1:0]       r_ev_addr;
    logic [RW-1:0]       r_ev_idx;
    t_result             r_out;

    logic [AW-1:0]       n_base;
    logic [RW-1:0]       rd_idx;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       fill_addr;
    logic                overlap;
    logic                contains;
    logic                ev_wr;
    logic                fill_wr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_desc               wr_data;
    t_result             n_out;

    // Request decode
    always_comb begin
        o_stat.is_read = (i_f_cmd == CMD_READ);
        o_stat.bad     = (i_f_unit >= r_unit_count)
                      || (int'(i_f_unit) >= UNITS)
                      || (int'(i_f_domain) >= DOMAINS);
        if (i_f_cmd == CMD_READ) begin
            o_stat.bad = o_stat.bad || (int'(i_f_slot) >= REGIONS);
        end else begin
            o_stat.bad = o_stat.bad || (i_f_group >= GROUP_LIMIT);
        end
    end

    assign n_base    = AW'((int'(i_f_unit) * DOMAINS + int'(i_f_domain)) * REGIONS);
    assign rd_idx    = i_cmd.rd_slot ? RW'(r_slot) : i_idx;
    assign rd_addr   = r_base + AW'(rd_idx);
    assign fill_addr = r_base + AW'(r_free_idx);

    assign overlap  = r_rd_vld && (r_astart < r_rd.gran_hi) && (r_aend > r_rd.gran_lo);
    assign contains = (r_astart >= r_rd.gran_lo) && (r_aend <= r_rd.gran_hi);
    assign ev_wr    = i_cmd.eval && overlap;
    assign fill_wr  = i_cmd.fill && !r_hit && r_have_free;
    assign wr_en    = ev_wr || fill_wr;
    assign wr_addr  = ev_wr ? r_ev_addr : fill_addr;

    always_comb begin
        if (ev_wr) begin
            // keep bounds, take new group and security bit
            wr_data           = r_rd;
            wr_data.group     = r_group;
            wr_data.nonsecure = r_ns;
        end else begin
            wr_data.gran_lo   = r_astart;
            wr_data.gran_hi   = r_aend;
            wr_data.group     = r_group;
            wr_data.nonsecure = r_ns;
        end
    end

    always_comb begin
        n_out = '0;
        if (r_bad) begin
            n_out.status = ST_INVALID;
        end else if (r_is_read) begin
            n_out.status     = ST_OK;
            n_out.read_valid = r_rd_vld;
            if (r_rd_vld) begin
                n_out.read_start     = r_rd.gran_lo;
                n_out.read_end       = r_rd.gran_hi;
                n_out.read_group     = r_rd.group;
                n_out.read_nonsecure = r_rd.nonsecure;
            end
        end else if (r_hit) begin
            n_out.status  = ST_OK;
            n_out.covered = 1'b1;
        end else if (!r_have_free) begin
            n_out.status = ST_NO_FREE;
        end else begin
            n_out.status    = ST_OK;
            n_out.new_entry = 1'b1;
            n_out.new_slot  = 3'(r_free_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_count <= UNIT_COUNT_RST;
            r_hit        <= 1'b0;
            r_have_free  <= 1'b0;
            r_free_idx   <= '0;
            r_vld        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_unit_count <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
                r_free_idx  <= '0;
            end else if (i_cmd.eval) begin
                if (overlap && contains) begin
                    r_hit <= 1'b1;
                end
                // note the first empty slot
                if (!r_rd_vld && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_ev_idx;
                end
            end
            if (fill_wr) begin
                r_vld[fill_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_read <= o_stat.is_read;
            r_bad     <= o_stat.bad;
            r_base    <= n_base;
            r_astart  <= i_f_start[GRAN_SHIFT +: GRAN_W];
            r_aend    <= i_f_end[GRAN_SHIFT +: GRAN_W];
            r_group   <= i_f_group[GROUP_W-1:0];
            r_ns      <= !i_f_secure_only;
            r_slot    <= i_f_slot;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd      <= r_mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_ev_addr <= rd_addr;
            r_ev_idx  <= rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

>>> test/tb_memory_region_descriptor_update_top.sv
`timescale 1ns / 100ps

module tb_memory_region_descriptor_update_top;

    import mrdu_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 12;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int          HOLD_CYCLES  = 250;
    localparam int          SETTLE       = REGIONS_DEF + 12;
    localparam int          PHASES       = 6;

    typedef struct {
        logic        cmd;
        logic [1:0]  unit;
        logic [3:0]  domain;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic        secure_only;
        logic [3:0]  group_id;
        logic [2:0]  slot;
    } req_t;

    typedef struct {
        req_t    req;
        bit      typed;
        t_result want;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_data = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    // Predicted descriptor table and register
    logic [GRAN_W-1:0]  d_lo  [UNITS_DEF][DOMAINS_DEF][REGIONS_DEF];
    logic [GRAN_W-1:0]  d_hi  [UNITS_DEF][DOMAINS_DEF][REGIONS_DEF];
    logic [GROUP_W-1:0] d_grp [UNITS_DEF][DOMAINS_DEF][REGIONS_DEF];
    logic               d_vld [UNITS_DEF][DOMAINS_DEF][REGIONS_DEF];
    logic               d_ns  [UNITS_DEF][DOMAINS_DEF][REGIONS_DEF];
    logic [1:0]         unit_cnt = UNIT_COUNT_RST;

    t_result     predicted_results[$];
    dir_row_t    directed_rows[$];
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    bit          hold_req = 1'b0;

    memory_region_descriptor_update_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic req_t mk_req(logic cmd, logic [1:0] unit, logic [3:0] domain,
                                    logic [31:0] a_lo, logic [31:0] a_hi,
                                    logic sec, logic [3:0] grp, logic [2:0] slot);
        req_t r;
        r.cmd = cmd;
        r.unit = unit;
        r.domain = domain;
        r.range_start = a_lo;
        r.range_end = a_hi;
        r.secure_only = sec;
        r.group_id = grp;
        r.slot = slot;
        return r;
    endfunction

    function automatic t_result mk_res(t_status st, logic cov, logic fill, logic [2:0] idx);
        t_result res;
        res = '0;
        res.status = st;
        res.covered = cov;
        res.new_entry = fill;
        res.new_slot = idx;
        return res;
    endfunction

    // Apply one request to the predicted table and return its result
    function automatic t_result region_update(req_t r);
        t_result           res;
        logic [GRAN_W-1:0] lo;
        logic [GRAN_W-1:0] hi;
        int                free_idx;
        bit                hit;
        res = '0;
        free_idx = -1;
        hit = 1'b0;
        if (r.unit >= unit_cnt || r.unit >= UNITS_DEF) begin
            res.status = ST_INVALID;
            return res;
        end
        if (r.cmd == CMD_READ) begin
            res.read_start = d_lo[r.unit][r.domain][r.slot];
            res.read_end = d_hi[r.unit][r.domain][r.slot];
            res.read_group = d_grp[r.unit][r.domain][r.slot];
            res.read_valid = d_vld[r.unit][r.domain][r.slot];
            res.read_nonsecure = d_ns[r.unit][r.domain][r.slot];
            return res;
        end
        if (r.group_id >= GROUP_LIMIT) begin
            res.status = ST_INVALID;
            return res;
        end
        lo = r.range_start[ADDR_W-1:GRAN_SHIFT];
        hi = r.range_end[ADDR_W-1:GRAN_SHIFT];
        for (int i = 0; i < REGIONS_DEF; i++) begin
            if (d_lo[r.unit][r.domain][i] == '0 && d_hi[r.unit][r.domain][i] == '0 &&
                !d_vld[r.unit][r.domain][i] && free_idx < 0)
                free_idx = i;
            if (d_vld[r.unit][r.domain][i] && lo < d_hi[r.unit][r.domain][i] &&
                hi > d_lo[r.unit][r.domain][i]) begin
                d_grp[r.unit][r.domain][i] = r.group_id[GROUP_W-1:0];
                d_ns[r.unit][r.domain][i] = !r.secure_only;
                if (lo >= d_lo[r.unit][r.domain][i] && hi <= d_hi[r.unit][r.domain][i])
                    hit = 1'b1;
            end
        end
        if (hit) begin
            res.covered = 1'b1;
        end else if (free_idx < 0) begin
            res.status = ST_NO_FREE;
        end else begin
            d_lo[r.unit][r.domain][free_idx] = lo;
            d_hi[r.unit][r.domain][free_idx] = hi;
            d_grp[r.unit][r.domain][free_idx] = r.group_id[GROUP_W-1:0];
            d_vld[r.unit][r.domain][free_idx] = 1'b1;
            d_ns[r.unit][r.domain][free_idx] = !r.secure_only;
            res.new_entry = 1'b1;
            res.new_slot = 3'(free_idx);
        end
        return res;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        int unsigned s;
        int unsigned lo_g;
        int unsigned hi_g;
        int unsigned base;
        int unsigned span;
        r = mk_req(($urandom_range(0, 99) < 40) ? CMD_READ : CMD_CONFIG,
                   ($urandom_range(0, 99) < 85) ? 2'($urandom_range(0, 1))
                                                : 2'($urandom_range(2, 3)),
                   ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom),
                   $urandom, $urandom, 1'($urandom),
                   ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 7))
                                                : 4'($urandom_range(8, 15)),
                   3'($urandom));
        pick = $urandom_range(0, 99);
        base = $urandom_range(0, 63);
        span = $urandom_range(0, 12);
        if (pick < 35 && r.unit < UNITS_DEF) begin
            // pick a sub-range of a stored descriptor so the walk can find it covered
            s = $urandom_range(0, REGIONS_DEF - 1);
            lo_g = d_lo[r.unit][r.domain][s];
            hi_g = d_hi[r.unit][r.domain][s];
            if (hi_g > lo_g) begin
                lo_g = lo_g + $urandom_range(0, hi_g - lo_g);
                hi_g = lo_g + $urandom_range(0, hi_g - lo_g);
            end
            r.range_start[ADDR_W-1:GRAN_SHIFT] = GRAN_W'(lo_g);
            r.range_end[ADDR_W-1:GRAN_SHIFT] = GRAN_W'(hi_g);
        end else if (pick < 80) begin
            r.range_start[ADDR_W-1:GRAN_SHIFT] = GRAN_W'(base);
            r.range_end[ADDR_W-1:GRAN_SHIFT] = GRAN_W'(base + span);
        end else if (pick < 88) begin
            r.range_start[ADDR_W-1:GRAN_SHIFT] = GRAN_W'(base + span);
            r.range_end[ADDR_W-1:GRAN_SHIFT] = GRAN_W'(base);
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 3)
            burst_left = $urandom_range(20, 50);
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_request(req_t r, bit typed, t_result want);
        int unsigned gap;
        t_result     pred;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {2'b00, r.slot, r.group_id, r.secure_only, r.range_end, r.range_start,
                    r.domain, r.unit};
        s_tuser <= r.cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = region_update(r);
        predicted_results.push_back(typed ? want : pred);
    endtask

    task automatic wait_drain();
        while (predicted_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_unit_count(logic [1:0] value);
        wait_drain();
        repeat (SETTLE) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        unit_cnt = value;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Result side: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        got = t_result'(o_m_axis_tdata);
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (predicted_results.size() == 0) begin
                err_count++;
                $display("%0t: result with none pending, expected none, got %h",
                         $time, o_m_axis_tdata);
            end else begin
                want = predicted_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("covered", want.covered, got.covered);
                check_field("new_entry", want.new_entry, got.new_entry);
                check_field("new_slot", want.new_slot, got.new_slot);
                check_field("read_start", want.read_start, got.read_start);
                check_field("read_end", want.read_end, got.read_end);
                check_field("read_group", want.read_group, got.read_group);
                check_field("read_valid", want.read_valid, got.read_valid);
                check_field("read_nonsecure", want.read_nonsecure, got.read_nonsecure);
            end
        end
    end

    initial begin
        int unsigned n;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // long hold-off so the output register fills and the input stalls
                m_ready <= 1'b0;
                n = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < 65) begin
                m_ready <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 12);
            end else begin
                m_ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50)
                                                : $urandom_range(1, 4);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    initial begin
        int unsigned phase_items [PHASES] = '{400, 300, 50, 400, 350, 300};
        logic [1:0]  phase_count [PHASES] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2};
        dir_row_t    row;
        t_result     zero_res;

        zero_res = '0;
        for (int u = 0; u < UNITS_DEF; u++)
            for (int d = 0; d < DOMAINS_DEF; d++)
                for (int s = 0; s < REGIONS_DEF; s++) begin
                    d_lo[u][d][s] = '0;
                    d_hi[u][d][s] = '0;
                    d_grp[u][d][s] = '0;
                    d_vld[u][d][s] = 1'b0;
                    d_ns[u][d][s] = 1'b0;
                end

        directed_rows.push_back('{mk_req(CMD_READ, 2'd0, 4'd0, '0, '0, 1'b0, 4'd0, 3'd0),
                                  1'b1, mk_res(ST_OK, 0, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_READ, 2'd3, 4'd15, '1, '1, 1'b1, 4'd15, 3'd7),
                                  1'b1, mk_res(ST_INVALID, 0, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd2, 4'd0, 32'h4000, 32'h8000, 1'b0,
                                         4'd0, 3'd0), 1'b1, mk_res(ST_INVALID, 0, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd0, 32'h4000, 32'h8000, 1'b0,
                                         GROUP_LIMIT, 3'd0), 1'b1, mk_res(ST_INVALID, 0, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd0, 32'h4000, 32'h8000, 1'b0,
                                         4'd15, 3'd0), 1'b1, mk_res(ST_INVALID, 0, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd0, 32'h4000, 32'h1_0000, 1'b0,
                                         4'd7, 3'd0), 1'b1, mk_res(ST_OK, 0, 1, 0)});
        // inside the range just stored: covered, group rewritten
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd0, 32'hBFFF, 32'hC000, 1'b1,
                                         4'd3, 3'd0), 1'b1, mk_res(ST_OK, 1, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_READ, 2'd0, 4'd0, '0, '0, 1'b0, 4'd0, 3'd0),
                                  1'b0, zero_res});
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd1, 4'd15, '1, '1, 1'b1, 4'd0, 3'd0),
                                  1'b1, mk_res(ST_OK, 0, 1, 0)});
        // a valid descriptor at granule zero is not empty
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd1, 4'd15, '0, '0, 1'b0, 4'd5, 3'd0),
                                  1'b0, zero_res});
        directed_rows.push_back('{mk_req(CMD_READ, 2'd1, 4'd15, '0, '0, 1'b0, 4'd0, 3'd0),
                                  1'b0, zero_res});
        directed_rows.push_back('{mk_req(CMD_READ, 2'd1, 4'd15, '0, '0, 1'b0, 4'd0, 3'd1),
                                  1'b0, zero_res});
        for (int k = 0; k < REGIONS_DEF; k++)
            directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd1, 32'(k) << 16,
                                             (32'(k) << 16) + 32'h8000, 1'(k), 4'(k),
                                             3'd0), 1'b0, zero_res});
        // table full; overlapping rewrites are kept even though the request fails
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd1, 32'h0, 32'h1_8000, 1'b1,
                                         4'd2, 3'd0), 1'b1, mk_res(ST_NO_FREE, 0, 0, 0)});
        directed_rows.push_back('{mk_req(CMD_READ, 2'd0, 4'd1, '0, '0, 1'b0, 4'd0, 3'd1),
                                  1'b0, zero_res});
        directed_rows.push_back('{mk_req(CMD_CONFIG, 2'd0, 4'd1, 32'h2_0000, 32'h2_4000, 1'b0,
                                         4'd6, 3'd0), 1'b0, zero_res});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.req, row.typed, row.want);
        end
        s_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            write_unit_count(phase_count[p]);
            for (int unsigned i = 0; i < phase_items[p]; i++) begin
                if (p == 0 && i == 150) begin
                    hold_req = 1'b1;
                    burst_left = 60;
                end
                send_request(random_request(), 1'b0, zero_res);
            end
            s_valid <= 1'b0;
        end

        wait_drain();
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/mrdu_pkg.sv
rtl/mrdu_ctrl.sv
rtl/mrdu_dp.sv
rtl/memory_region_descriptor_update_top.sv
test/tb_memory_region_descriptor_update_top.sv
